// ===== rtl/aabb_all_pairs_overlap_defines.svh =====
// shared assertion macros for the box overlap block
`ifndef AABB_ALL_PAIRS_OVERLAP_DEFINES_SVH
`define AABB_ALL_PAIRS_OVERLAP_DEFINES_SVH

// condition must hold in the same cycle
`define AAP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("aabb overlap check failed");

// condition must hold in the next cycle
`define AAP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("aabb overlap check failed");

`endif

// ===== rtl/aap_pkg.sv =====
package aap_pkg;

   localparam int COORD_BITS    = 24;
   localparam int HALF_BITS     = COORD_BITS - 1;
   localparam int INDEX_BITS    = 6;
   localparam int MASK_BITS     = 32;
   localparam int MAX_BOXES_DEF = 32;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] center_x;
      logic signed [COORD_BITS-1:0] center_y;
      logic signed [COORD_BITS-1:0] center_z;
      logic [HALF_BITS-1:0]         half_x;
      logic [HALF_BITS-1:0]         half_y;
      logic [HALF_BITS-1:0]         half_z;
      logic                         last_box;
   } req_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0] box_index;
      logic [MASK_BITS-1:0]  overlap_mask;
      logic                  last_row;
   } rsp_type;

   // one stored box
   typedef struct packed {
      logic signed [COORD_BITS-1:0] center_x;
      logic signed [COORD_BITS-1:0] center_y;
      logic signed [COORD_BITS-1:0] center_z;
      logic [HALF_BITS-1:0]         half_x;
      logic [HALF_BITS-1:0]         half_y;
      logic [HALF_BITS-1:0]         half_z;
   } box_rec_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_START,
      ST_SCAN,
      ST_WAIT,
      ST_EMIT
   } state_type;

endpackage

// ===== rtl/aap_box_cmp.sv =====
module aap_box_cmp (
   input  aap_pkg::box_rec_type box_a,
   input  aap_pkg::box_rec_type box_b,
   output logic                 hit
);

   localparam int CB = aap_pkg::COORD_BITS;

   // |ca - cb| < ha + hb, done as -s < d < s at two bits above the coordinate width
   function automatic logic axis_hit(input logic [CB-1:0] ca, input logic [CB-1:0] cb,
                                     input logic [CB-2:0] ha, input logic [CB-2:0] hb);
      logic [CB+1:0] d;
      logic [CB+1:0] s;
      logic [CB+1:0] hi_chk;
      logic [CB+1:0] lo_chk;
      d      = {{2{ca[CB-1]}}, ca} - {{2{cb[CB-1]}}, cb};
      s      = {3'b000, ha} + {3'b000, hb};
      hi_chk = d - s;
      lo_chk = d + s;
      return hi_chk[CB+1] && !lo_chk[CB+1] && (lo_chk != '0);
   endfunction

   logic hit_x;
   logic hit_y;
   logic hit_z;

   assign hit_x = axis_hit(box_a.center_x, box_b.center_x, box_a.half_x, box_b.half_x);
   assign hit_y = axis_hit(box_a.center_y, box_b.center_y, box_a.half_y, box_b.half_y);
   assign hit_z = axis_hit(box_a.center_z, box_b.center_z, box_a.half_z, box_b.half_z);
   assign hit   = hit_x && hit_y && hit_z;

endmodule

// ===== rtl/aabb_all_pairs_overlap.sv =====
// all-pairs box overlap broadphase
// req channel: one box per transfer (center and half extents). boxes are kept in
// load order; the transfer with last_box set closes the set and starts the test.
// boxes beyond MAX_BOXES are dropped, but their last_box flag still starts it.
// rsp channel: one row per stored box, in index order, with a mask of the
// higher-indexed boxes (below 32) it overlaps; last_row marks the final row.
// after the closing box, each row steps through ST_START, then ST_SCAN and
// ST_WAIT when it has pairs (higher boxes below min(N, 32)), then ST_EMIT;
// the scan makes one pair test per cycle, paced by the two read ports of the
// box memory feeding a single comparator.
// req_ready is low from the closing box until the last row sits in the output
// register, so the next set can load while that row waits.
// a stalled rsp holds its row; the next row is scanned and waits in ST_EMIT.
// reset (synchronous) empties the set and drops any run in progress; the box
// memory itself is not cleared.
module aabb_all_pairs_overlap #(
   parameter int MAX_BOXES = aap_pkg::MAX_BOXES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  aap_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output aap_pkg::rsp_type rsp_data
);

   localparam int CW      = $clog2(MAX_BOXES + 1);
   localparam int AW      = $clog2(MAX_BOXES);
   localparam int LIM_MAX = (MAX_BOXES < aap_pkg::MASK_BITS) ? MAX_BOXES : aap_pkg::MASK_BITS;

   aap_pkg::box_rec_type box_mem [MAX_BOXES];

   aap_pkg::state_type   state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        i_ff, i_in;
   logic [CW-1:0]        k_ff, k_in;
   logic                 pend_ff, pend_in;
   logic [CW-1:0]        pend_k_ff;
   logic [aap_pkg::MASK_BITS-1:0] mask_ff, mask_in;
   aap_pkg::box_rec_type rd_a_ff, rd_b_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   aap_pkg::rsp_type     rsp_data_ff;

   logic                 req_xfer;
   logic                 wr_en;
   logic                 rd_en;
   logic                 load_rsp;
   logic                 hit;
   logic [CW-1:0]        lim;
   logic [CW-1:0]        i_next;
   logic [CW-1:0]        k_next;
   aap_pkg::box_rec_type wr_rec;

   assign req_xfer = req_valid && req_ready;
   assign wr_en    = req_xfer && (count_ff < CW'(MAX_BOXES));
   assign lim      = (count_ff > CW'(LIM_MAX)) ? CW'(LIM_MAX) : count_ff;
   assign i_next   = CW'(i_ff + 1'b1);
   assign k_next   = CW'(k_ff + 1'b1);

   assign wr_rec.center_x = req_data.center_x;
   assign wr_rec.center_y = req_data.center_y;
   assign wr_rec.center_z = req_data.center_z;
   assign wr_rec.half_x   = req_data.half_x;
   assign wr_rec.half_y   = req_data.half_y;
   assign wr_rec.half_z   = req_data.half_z;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      mask_in      = mask_ff;
      pend_in      = 1'b0;
      rd_en        = 1'b0;
      load_rsp     = 1'b0;
      req_ready    = 1'b0;
      if (pend_ff && hit) begin
         mask_in = mask_ff | (aap_pkg::MASK_BITS'(1) << pend_k_ff);
      end
      unique case (state_ff)
         aap_pkg::ST_LOAD: begin
            req_ready = 1'b1;
            if (req_xfer) begin
               if (wr_en) begin
                  count_in = CW'(count_ff + 1'b1);
               end
               if (req_data.last_box) begin
                  i_in     = '0;
                  state_in = aap_pkg::ST_START;
               end
            end
         end
         aap_pkg::ST_START: begin
            k_in    = i_next;
            mask_in = '0;
            if (i_next < lim) begin
               state_in = aap_pkg::ST_SCAN;
            end else begin
               state_in = aap_pkg::ST_EMIT;
            end
         end
         aap_pkg::ST_SCAN: begin
            rd_en   = 1'b1;
            pend_in = 1'b1;
            if (k_next < lim) begin
               k_in = k_next;
            end else begin
               state_in = aap_pkg::ST_WAIT;
            end
         end
         aap_pkg::ST_WAIT: begin
            // last compare of the row lands in the mask at this edge
            state_in = aap_pkg::ST_EMIT;
         end
         aap_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               if (i_next == count_ff) begin
                  count_in = '0;
                  state_in = aap_pkg::ST_LOAD;
               end else begin
                  i_in     = i_next;
                  state_in = aap_pkg::ST_START;
               end
            end
         end
         default: begin
            state_in = aap_pkg::ST_LOAD;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= aap_pkg::ST_LOAD;
         count_ff     <= '0;
         i_ff         <= '0;
         k_ff         <= '0;
         pend_ff      <= 1'b0;
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         i_ff         <= i_in;
         k_ff         <= k_in;
         pend_ff      <= pend_in;
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_k_ff <= k_ff;
      if (load_rsp) begin
         rsp_data_ff.box_index    <= aap_pkg::INDEX_BITS'(i_ff);
         rsp_data_ff.overlap_mask <= mask_ff;
         rsp_data_ff.last_row     <= (i_next == count_ff);
      end
   end

   // box memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         box_mem[count_ff[AW-1:0]] <= wr_rec;
      end
      if (rd_en) begin
         rd_a_ff <= box_mem[i_ff[AW-1:0]];
         rd_b_ff <= box_mem[k_ff[AW-1:0]];
      end
   end

   aap_box_cmp u_cmp (
      .box_a (rd_a_ff),
      .box_b (rd_b_ff),
      .hit   (hit)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/aap_checker.sv =====
`include "aabb_all_pairs_overlap_defines.svh"

module aap_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input aap_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input aap_pkg::rsp_type rsp_data
);

   logic [aap_pkg::MASK_BITS-1:0] low_bits;
   logic                          rsp_stall;
   logic                          close_xfer;

   // bits at and below the reported box
   assign low_bits   = ~(({aap_pkg::MASK_BITS{1'b1}} << rsp_data.box_index) << 1);
   assign rsp_stall  = rsp_valid && !rsp_ready;
   assign close_xfer = req_valid && req_ready && req_data.last_box;

   `AAP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data))
   `AAP_ASSERT_NOW(a_mask_upper, clock, reset, rsp_valid, (rsp_data.overlap_mask & low_bits) == '0)
   `AAP_ASSERT_NOW(a_no_load_mid_run, clock, reset, rsp_valid && !rsp_data.last_row, !req_ready)
   `AAP_ASSERT_NEXT(a_close_stops_load, clock, reset, close_xfer, !req_ready)

endmodule

bind aabb_all_pairs_overlap aap_checker u_aap_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

   localparam int BOX_CAP = aap_pkg::MAX_BOXES_DEF;

   typedef struct {
      aap_pkg::req_type box;
      bit               typed;
      aap_pkg::rsp_type row;
   } stim_row_type;

   logic             clock;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   aap_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   aap_pkg::rsp_type rsp_data;

   aap_pkg::box_rec_type loaded_boxes[$];
   aap_pkg::rsp_type     expected_rows[$];
   int                   send_idle_pct = 0;
   int                   recv_idle_pct = 0;
   int                   rsp_hold      = 0;
   int                   errors        = 0;

   aabb_all_pairs_overlap #(.MAX_BOXES(BOX_CAP)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // strict compare at full width: |ca - cb| < ha + hb
   function automatic bit axis_hit(logic signed [aap_pkg::COORD_BITS-1:0] ca,
                                   logic signed [aap_pkg::COORD_BITS-1:0] cb,
                                   logic [aap_pkg::HALF_BITS-1:0] ha,
                                   logic [aap_pkg::HALF_BITS-1:0] hb);
      longint gap;
      gap = longint'(ca) - longint'(cb);
      if (gap < 0) gap = -gap;
      return gap < (longint'(ha) + longint'(hb));
   endfunction

   // store one box; the closing box yields one row per stored box
   function automatic void store_box_and_scan(input aap_pkg::req_type b,
                                              output aap_pkg::rsp_type rows[$]);
      aap_pkg::box_rec_type rec;
      aap_pkg::rsp_type     row;
      int                   n;
      rows = {};
      if (loaded_boxes.size() < BOX_CAP) begin
         rec.center_x = b.center_x;
         rec.center_y = b.center_y;
         rec.center_z = b.center_z;
         rec.half_x   = b.half_x;
         rec.half_y   = b.half_y;
         rec.half_z   = b.half_z;
         loaded_boxes.push_back(rec);
      end
      if (b.last_box) begin
         n = loaded_boxes.size();
         for (int i = 0; i < n; i++) begin
            row.box_index    = aap_pkg::INDEX_BITS'(i);
            row.overlap_mask = '0;
            row.last_row     = (i == n - 1);
            for (int k = i + 1; k < n && k < aap_pkg::MASK_BITS; k++) begin
               if (axis_hit(loaded_boxes[i].center_x, loaded_boxes[k].center_x,
                            loaded_boxes[i].half_x, loaded_boxes[k].half_x) &&
                   axis_hit(loaded_boxes[i].center_y, loaded_boxes[k].center_y,
                            loaded_boxes[i].half_y, loaded_boxes[k].half_y) &&
                   axis_hit(loaded_boxes[i].center_z, loaded_boxes[k].center_z,
                            loaded_boxes[i].half_z, loaded_boxes[k].half_z))
                  row.overlap_mask[k] = 1'b1;
            end
            rows.push_back(row);
         end
         loaded_boxes = {};
      end
   endfunction

   function automatic stim_row_type stim(int cx, int cy, int cz, int hx, int hy, int hz,
                                         bit last, bit typed = 1'b0);
      stim_row_type s;
      s.box.center_x = aap_pkg::COORD_BITS'(cx);
      s.box.center_y = aap_pkg::COORD_BITS'(cy);
      s.box.center_z = aap_pkg::COORD_BITS'(cz);
      s.box.half_x   = aap_pkg::HALF_BITS'(hx);
      s.box.half_y   = aap_pkg::HALF_BITS'(hy);
      s.box.half_z   = aap_pkg::HALF_BITS'(hz);
      s.box.last_box = last;
      s.typed        = typed;
      // a set of one box: row 0, empty mask, final row
      s.row.box_index    = '0;
      s.row.overlap_mask = '0;
      s.row.last_row     = 1'b1;
      return s;
   endfunction

   task automatic send_box(input aap_pkg::req_type item, input bit typed = 1'b0,
                           input aap_pkg::rsp_type typed_row = '0);
      aap_pkg::rsp_type rows[$];
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      store_box_and_scan(item, rows);
      if (typed && item.last_box) rows = {typed_row};
      foreach (rows[i]) expected_rows.push_back(rows[i]);
   endtask

   // mostly clustered boxes so that overlaps are common, some fully random ones
   task automatic send_set(input int count);
      aap_pkg::req_type                      b;
      logic signed [aap_pkg::COORD_BITS-1:0] base_x, base_y, base_z;
      int                                    spread;
      spread = 1 << $urandom_range(2, 21);
      base_x = aap_pkg::COORD_BITS'($urandom);
      base_y = aap_pkg::COORD_BITS'($urandom);
      base_z = aap_pkg::COORD_BITS'($urandom);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(4) == 0) begin
            b.center_x = aap_pkg::COORD_BITS'($urandom);
            b.center_y = aap_pkg::COORD_BITS'($urandom);
            b.center_z = aap_pkg::COORD_BITS'($urandom);
            b.half_x   = aap_pkg::HALF_BITS'($urandom);
            b.half_y   = aap_pkg::HALF_BITS'($urandom);
            b.half_z   = aap_pkg::HALF_BITS'($urandom);
         end else begin
            b.center_x = base_x + aap_pkg::COORD_BITS'($urandom_range(2 * spread))
                         - aap_pkg::COORD_BITS'(spread);
            b.center_y = base_y + aap_pkg::COORD_BITS'($urandom_range(2 * spread))
                         - aap_pkg::COORD_BITS'(spread);
            b.center_z = base_z + aap_pkg::COORD_BITS'($urandom_range(2 * spread))
                         - aap_pkg::COORD_BITS'(spread);
            b.half_x   = ($urandom_range(7) == 0) ? '0
                         : aap_pkg::HALF_BITS'($urandom_range(spread));
            b.half_y   = ($urandom_range(7) == 0) ? '0
                         : aap_pkg::HALF_BITS'($urandom_range(spread));
            b.half_z   = ($urandom_range(7) == 0) ? '0
                         : aap_pkg::HALF_BITS'($urandom_range(spread));
         end
         b.last_box = (i == count - 1);
         send_box(b);
      end
   endtask

   task automatic drain_rows;
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rows.size() != 0) @(posedge clock);
   endtask

   // receiver: random back-pressure, plus a long hold when asked
   initial begin
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      aap_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rows.size() == 0) begin
            $error("row with nothing expected: box_index %0d mask %h last_row %0d",
                   rsp_data.box_index, rsp_data.overlap_mask, rsp_data.last_row);
            errors++;
         end else begin
            want = expected_rows.pop_front();
            if (rsp_data.box_index !== want.box_index) begin
               $error("box_index: expected %0d, got %0d", want.box_index, rsp_data.box_index);
               errors++;
            end
            if (rsp_data.overlap_mask !== want.overlap_mask) begin
               $error("overlap_mask: expected %h, got %h", want.overlap_mask,
                      rsp_data.overlap_mask);
               errors++;
            end
            if (rsp_data.last_row !== want.last_row) begin
               $error("last_row: expected %0d, got %0d", want.last_row, rsp_data.last_row);
               errors++;
            end
         end
      end
   end

   initial begin
      stim_row_type tab[$];
      int           phase_items;
      int           n;

      tab.push_back(stim(0, 0, 0, 0, 0, 0, 1, 1));
      tab.push_back(stim(8388607, 8388607, 8388607, 8388607, 8388607, 8388607, 1, 1));
      tab.push_back(stim(-8388608, -8388608, -8388608, 0, 0, 0, 1, 1));
      // same center, unit extents
      tab.push_back(stim(0, 0, 0, 1, 1, 1, 0));
      tab.push_back(stim(0, 0, 0, 1, 1, 1, 1));
      // zero extent sum on x never overlaps
      tab.push_back(stim(100, 100, 100, 0, 50, 50, 0));
      tab.push_back(stim(100, 100, 100, 0, 50, 50, 1));
      // touching faces: distance equals extent sum; then a pair just inside it
      tab.push_back(stim(0, 0, 0, 5, 5, 5, 0));
      tab.push_back(stim(10, 0, 0, 5, 5, 5, 1));
      tab.push_back(stim(0, 0, 0, 5, 5, 5, 0));
      tab.push_back(stim(9, -3, 2, 5, 5, 5, 1));
      // opposite corners of the range, distance wider than the field
      tab.push_back(stim(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607, 0));
      tab.push_back(stim(8388607, 8388607, 8388607, 8388607, 8388607, 8388607, 1));
      tab.push_back(stim(-8388606, -8388606, -8388606, 8388607, 8388607, 8388607, 0));
      tab.push_back(stim(8388607, 8388607, 8388607, 8388607, 8388607, 8388607, 1));
      tab.push_back(stim(-1000, -1000, -1000, 300, 300, 300, 0));
      tab.push_back(stim(-600, -1000, -1000, 200, 300, 300, 0));
      tab.push_back(stim(-1000, -500, -1000, 300, 300, 300, 0));
      tab.push_back(stim(-700, -800, -900, 100, 100, 100, 1));
      tab.push_back(stim(5000, 5000, 5000, 10, 10, 10, 0));
      tab.push_back(stim(5000, 5000, 5020, 10, 10, 9, 0));
      tab.push_back(stim(5000, 5000, 5019, 10, 10, 10, 1));
      tab.push_back(stim(-1, 1, -1, 4194304, 2, 3, 1, 1));

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 20;
      recv_idle_pct = 57;
      foreach (tab[i]) send_box(tab[i].box, tab[i].typed, tab[i].row);
      drain_rows();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 57 : 0;
         recv_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 20 : 0;
         phase_items   = 0;
         if (phase == 0) begin
            // hold the result side while more sets queue up behind it
            send_set(6);
            rsp_hold = 400;
            send_set(6);
            send_set(5);
            phase_items = 17;
         end
         if (phase == 1) begin
            // more boxes than the store holds
            n = $urandom_range(BOX_CAP + 1, BOX_CAP + 4);
            send_set(n);
            phase_items = n;
         end
         while (phase_items < 22) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
            send_set(n);
            phase_items += n;
         end
         drain_rows();
      end

      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== aabb_all_pairs_overlap.f =====
+incdir+rtl
rtl/aap_pkg.sv
rtl/aap_box_cmp.sv
rtl/aabb_all_pairs_overlap.sv
rtl/aap_checker.sv
tb/tb_top.sv
